// ----- sv/sat_pkg.sv -----
package sat_pkg;

   localparam int MAC_W   = 48;
   localparam int ADDR_W  = 32;
   localparam int STAMP_W = 64;
   localparam int CMD_W   = 3;
   localparam int STAT_W  = 2;
   localparam int SLOT_W  = 3;
   localparam int COUNT_W = 4;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_ASSOCIATE    = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DISASSOCIATE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR_IP     = 3'd2;
   localparam logic [CMD_W-1:0] CMD_BIND_IP      = 3'd3;
   localparam logic [CMD_W-1:0] CMD_LOOKUP_IP    = 3'd4;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] ST_MISSING = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]  command;
      logic [MAC_W-1:0]  station_mac;
      logic [ADDR_W-1:0] ip_address;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [SLOT_W-1:0]  slot_index;
      logic [MAC_W-1:0]   found_mac;
      logic [COUNT_W-1:0] station_count;
   } rsp_type;

   // One stored table entry; the flags live in flip-flops beside the memory.
   typedef struct packed {
      logic [MAC_W-1:0]   mac;
      logic [ADDR_W-1:0]  address;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   // Compare results for the entry under scan.
   typedef struct packed {
      logic mac_eq;
      logic addr_eq;
      logic stamp_ge;
   } match_type;

endpackage

// ----- sv/sat_ram.sv -----
module sat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                                  clock,
   input  logic                                  wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                      wr_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/sat_match_unit.sv -----
// Shared comparator applied to every entry read during a table scan.
module sat_match_unit (
   input  sat_pkg::entry_type                entry,
   input  logic [sat_pkg::MAC_W-1:0]         key_mac,
   input  logic [sat_pkg::ADDR_W-1:0]        key_addr,
   input  logic [sat_pkg::STAMP_W-1:0]       newest,
   output sat_pkg::match_type                result
);

   always_comb begin
      result.mac_eq   = (entry.mac == key_mac);
      result.addr_eq  = (entry.address == key_addr);
      result.stamp_ge = (entry.stamp >= newest);
   end

endmodule

// ----- sv/station_address_table.sv -----
// Associate, disassociate, bind and lookup scan the table, one entry per cycle, before rsp_valid
// rises; clear and unused codes go straight to the result without a scan. A new item is taken
// only while idle, once the previous item has finished; a finished result that cannot leave
// holds the next one. Reset (synchronous, active high) empties the table, zeroes the station
// count and the generation counter and drops any pending result; no clearing pass is needed.
module station_address_table #(
   parameter int MAX_STATIONS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sat_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sat_pkg::rsp_type rsp_payload
);

   // Slot index width and a counter wide enough to hold MAX_STATIONS itself.
   localparam int IDXW = (MAX_STATIONS > 1) ? $clog2(MAX_STATIONS) : 1;
   localparam int CNTW = $clog2(MAX_STATIONS + 1);
   localparam logic [CNTW-1:0] LAST = CNTW'(MAX_STATIONS);

   // Sequencer states.
   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   // Control state.
   logic [1:0]              state_ff, state_in;
   logic [CNTW-1:0]         scan_ff, scan_in;
   logic [MAX_STATIONS-1:0] in_use_ff, in_use_in;
   logic [MAX_STATIONS-1:0] has_addr_ff, has_addr_in;
   logic [CNTW-1:0]         count_ff, count_in;
   logic [sat_pkg::STAMP_W-1:0] stamp_ctr_ff, stamp_ctr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    hit_ff, hit_in;
   logic                    free_ff, free_in;
   logic                    best_ff, best_in;

   // Payload state.
   sat_pkg::req_type            req_ff, req_in;
   logic [IDXW-1:0]             hit_slot_ff, hit_slot_in;
   logic [sat_pkg::STAMP_W-1:0] hit_stamp_ff, hit_stamp_in;
   logic [IDXW-1:0]             free_slot_ff, free_slot_in;
   logic [IDXW-1:0]             best_slot_ff, best_slot_in;
   logic [sat_pkg::STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [sat_pkg::MAC_W-1:0]   best_mac_ff, best_mac_in;
   sat_pkg::rsp_type            rsp_ff, rsp_in;

   // Entry memory and the shared comparator.
   logic                        ram_we;
   logic [IDXW-1:0]             ram_waddr;
   sat_pkg::entry_type          ram_wdata;
   logic [IDXW-1:0]             ram_raddr;
   logic [$bits(sat_pkg::entry_type)-1:0] ram_rdata;
   sat_pkg::entry_type          rd_entry;
   sat_pkg::match_type          match;

   logic                        req_xfer;
   logic                        commit;
   logic [CNTW-1:0]             prev_scan;
   logic [IDXW-1:0]             ev_slot;
   logic [IDXW+2:0]             slot_wide;
   logic [CNTW+3:0]             count_wide;
   logic [IDXW-1:0]             out_slot;

   assign req_stall = (state_ff != S_IDLE);
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // The result register may be reloaded once the previous result has left.
   assign commit = (state_ff == S_FINISH) && (!rsp_valid_ff || !rsp_stall);

   // The memory read is registered, so the entry under
   // evaluation is the one addressed on the previous scan step.
   assign ram_raddr = (scan_ff < LAST) ? scan_ff[IDXW-1:0] : '0;
   assign prev_scan = scan_ff - 1'b1;
   assign ev_slot   = prev_scan[IDXW-1:0];
   assign rd_entry  = sat_pkg::entry_type'(ram_rdata);

   sat_ram #(
      .WIDTH ($bits(sat_pkg::entry_type)),
      .DEPTH (MAX_STATIONS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   sat_match_unit u_match (
      .entry    (rd_entry),
      .key_mac  (req_ff.station_mac),
      .key_addr (req_ff.ip_address),
      .newest   (best_stamp_ff),
      .result   (match)
   );

   // Sequencer and scan bookkeeping.
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      req_in        = req_ff;
      hit_in        = hit_ff;
      hit_slot_in   = hit_slot_ff;
      hit_stamp_in  = hit_stamp_ff;
      free_in       = free_ff;
      free_slot_in  = free_slot_ff;
      best_in       = best_ff;
      best_slot_in  = best_slot_ff;
      best_stamp_in = best_stamp_ff;
      best_mac_in   = best_mac_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               req_in        = req_payload;
               scan_in       = '0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               best_in       = 1'b0;
               best_stamp_in = '0;
               case (req_payload.command)
                  sat_pkg::CMD_ASSOCIATE,
                  sat_pkg::CMD_DISASSOCIATE,
                  sat_pkg::CMD_BIND_IP,
                  sat_pkg::CMD_LOOKUP_IP: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_ff != '0) begin
               // First slot in scan order holding the MAC.
               if (in_use_ff[ev_slot] && match.mac_eq && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_slot_in  = ev_slot;
                  hit_stamp_in = rd_entry.stamp;
               end
               // Lowest free slot.
               if (!in_use_ff[ev_slot] && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = ev_slot;
               end
               // Newest entry bound to the address; ties go to the later slot.
               if (in_use_ff[ev_slot] && has_addr_ff[ev_slot] &&
                   match.addr_eq && match.stamp_ge) begin
                  best_in       = 1'b1;
                  best_slot_in  = ev_slot;
                  best_stamp_in = rd_entry.stamp;
                  best_mac_in   = rd_entry.mac;
               end
            end
            if (scan_ff == LAST) begin
               state_in = S_FINISH;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_FINISH: begin
            if (commit) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Table update and result formation at the end of an item.
   always_comb begin
      in_use_in    = in_use_ff;
      has_addr_in  = has_addr_ff;
      count_in     = count_ff;
      stamp_ctr_in = stamp_ctr_ff;
      ram_we       = 1'b0;
      ram_waddr    = '0;
      ram_wdata    = '0;
      out_slot     = '0;
      rsp_in.status    = sat_pkg::ST_MISSING;
      rsp_in.found_mac = '0;

      case (req_ff.command)
         sat_pkg::CMD_ASSOCIATE,
         sat_pkg::CMD_BIND_IP: begin
            if (hit_ff) begin
               out_slot      = hit_slot_ff;
               rsp_in.status = sat_pkg::ST_DONE;
               if (req_ff.command == sat_pkg::CMD_BIND_IP) begin
                  ram_we                   = commit;
                  ram_waddr                = hit_slot_ff;
                  ram_wdata.mac            = req_ff.station_mac;
                  ram_wdata.address        = req_ff.ip_address;
                  ram_wdata.stamp          = hit_stamp_ff;
                  has_addr_in[hit_slot_ff] = 1'b1;
               end
            end else if (free_ff) begin
               // Claim the slot: fresh entry with the next generation number.
               out_slot                  = free_slot_ff;
               rsp_in.status             = sat_pkg::ST_DONE;
               stamp_ctr_in              = stamp_ctr_ff + 1'b1;
               ram_we                    = commit;
               ram_waddr                 = free_slot_ff;
               ram_wdata.mac             = req_ff.station_mac;
               ram_wdata.address         = (req_ff.command == sat_pkg::CMD_BIND_IP) ?
                                           req_ff.ip_address : '0;
               ram_wdata.stamp           = stamp_ctr_ff + 1'b1;
               in_use_in[free_slot_ff]   = 1'b1;
               has_addr_in[free_slot_ff] = (req_ff.command == sat_pkg::CMD_BIND_IP);
               count_in                  = count_ff + 1'b1;
            end else begin
               rsp_in.status = sat_pkg::ST_FULL;
            end
         end
         sat_pkg::CMD_DISASSOCIATE: begin
            if (hit_ff) begin
               out_slot                 = hit_slot_ff;
               rsp_in.status            = sat_pkg::ST_DONE;
               in_use_in[hit_slot_ff]   = 1'b0;
               has_addr_in[hit_slot_ff] = 1'b0;
               count_in                 = count_ff - 1'b1;
            end
         end
         sat_pkg::CMD_CLEAR_IP: begin
            rsp_in.status = sat_pkg::ST_DONE;
            has_addr_in   = '0;
         end
         sat_pkg::CMD_LOOKUP_IP: begin
            if (best_ff) begin
               out_slot         = best_slot_ff;
               rsp_in.status    = sat_pkg::ST_DONE;
               rsp_in.found_mac = best_mac_ff;
            end
         end
         default: begin
            rsp_in.status = sat_pkg::ST_MISSING;
         end
      endcase

      // Slot and count are reported at their fixed field widths.
      slot_wide  = {3'b000, out_slot};
      count_wide = {4'b0000, count_in};
      rsp_in.slot_index    = slot_wide[sat_pkg::SLOT_W-1:0];
      rsp_in.station_count = count_wide[sat_pkg::COUNT_W-1:0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         scan_ff      <= '0;
         in_use_ff    <= '0;
         has_addr_ff  <= '0;
         count_ff     <= '0;
         stamp_ctr_ff <= '0;
         rsp_valid_ff <= 1'b0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         best_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         best_ff      <= best_in;
         if (commit) begin
            in_use_ff    <= in_use_in;
            has_addr_ff  <= has_addr_in;
            count_ff     <= count_in;
            stamp_ctr_ff <= stamp_ctr_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      hit_slot_ff   <= hit_slot_in;
      hit_stamp_ff  <= hit_stamp_in;
      free_slot_ff  <= free_slot_in;
      best_slot_ff  <= best_slot_in;
      best_stamp_ff <= best_stamp_in;
      best_mac_ff   <= best_mac_in;
      if (commit) begin
         rsp_ff <= rsp_in;
      end
   end

   // The running count always equals the number of occupied slots.
   a_count_matches: assert property (@(posedge clock) disable iff (reset)
      count_ff == CNTW'($countones(in_use_ff)))
      else $error("station count disagrees with occupied slots");

   // An accepted item always starts the sequencer.
   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != S_IDLE))
      else $error("accepted item did not leave idle");

   // A table-full answer is only given when every slot is occupied.
   a_full_only_when_full: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.status == sat_pkg::ST_FULL) |-> (count_ff == LAST))
      else $error("table full reported with a free slot");

endmodule
